FILE: rtl/fcmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcmc_pkg;

  localparam int CurWidth    = 12;
  localparam int JamWidth    = 16;
  localparam int ForkWidth   = 13;
  localparam int DtWidth     = 10;
  localparam int ModeWidth   = 3;
  localparam int ConvWidth   = 2;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CURRENT_LIMIT = 3'd0,
    CFG_JAM_TIME      = 3'd1,
    CFG_FORK_UP       = 3'd2,
    CFG_FORK_DOWN     = 3'd3,
    CFG_FORK_DRIVE    = 3'd4,
    CFG_FORK_LOAD     = 3'd5
  } cfg_idx_e;

  // Mode machine, one-hot
  typedef enum logic [4:0] {
    MODE_UP      = 5'b00001,
    MODE_DOWN    = 5'b00010,
    MODE_DRIVING = 5'b00100,
    MODE_LOADING = 5'b01000,
    MODE_UNJAM   = 5'b10000
  } mode_e;

  // Mode codes as reported on the result beat
  localparam logic [ModeWidth-1:0] MODE_CODE_UP      = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_CODE_DOWN    = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_CODE_DRIVING = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_CODE_LOADING = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_CODE_UNJAM   = 3'd4;

  typedef enum logic [ConvWidth-1:0] {
    CONV_STOP = 2'd0,
    CONV_FWD  = 2'd1,
    CONV_REV  = 2'd2
  } conv_e;

  localparam logic [JamWidth-1:0] JamMax = '1;

  localparam logic [CurWidth-1:0]  CurrentLimitRst = 12'd1000;
  localparam logic [JamWidth-1:0]  JamTimeRst      = 16'd500;
  localparam logic [ForkWidth-1:0] ForkUpRst       = 13'd0;
  localparam logic [ForkWidth-1:0] ForkDownRst     = 13'd2700;
  localparam logic [ForkWidth-1:0] ForkDriveRst    = 13'd1800;
  localparam logic [ForkWidth-1:0] ForkLoadRst     = 13'd1050;

  typedef struct packed {
    logic [CurWidth-1:0]  current_limit_ma;
    logic [JamWidth-1:0]  jam_time_ms;
    logic [ForkWidth-1:0] fork_up_mrev;
    logic [ForkWidth-1:0] fork_down_mrev;
    logic [ForkWidth-1:0] fork_drive_mrev;
    logic [ForkWidth-1:0] fork_load_mrev;
  } cfg_t;

  typedef struct packed {
    logic                lower_button;
    logic                collect_button;
    logic                goal_near;
    logic [CurWidth-1:0] conveyor_current_ma;
    logic [DtWidth-1:0]  elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic [ForkWidth-1:0] fork_target_mrev;
    logic [ConvWidth-1:0] conveyor_cmd;
    logic                 lift_clear;
  } res_t;

  function automatic logic [ModeWidth-1:0] mode_code(mode_e m);
    logic [ModeWidth-1:0] c;
    case (m)
      MODE_UP:      c = MODE_CODE_UP;
      MODE_DOWN:    c = MODE_CODE_DOWN;
      MODE_DRIVING: c = MODE_CODE_DRIVING;
      MODE_LOADING: c = MODE_CODE_LOADING;
      MODE_UNJAM:   c = MODE_CODE_UNJAM;
      default:      c = MODE_CODE_UP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fcmc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fcmc_in_if import fcmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                lower_button;
  logic                collect_button;
  logic                goal_near;
  logic [CurWidth-1:0] conveyor_current_ma;
  logic [DtWidth-1:0]  elapsed_ms;

  modport source (output valid, lower_button, collect_button, goal_near,
                  conveyor_current_ma, elapsed_ms, input ready);
  modport sink (input valid, lower_button, collect_button, goal_near,
                conveyor_current_ma, elapsed_ms, output ready);
endinterface

interface fcmc_out_if import fcmc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ModeWidth-1:0] mode;
  logic [ForkWidth-1:0] fork_target_mrev;
  logic [ConvWidth-1:0] conveyor_cmd;
  logic                 lift_clear;

  modport source (output valid, mode, fork_target_mrev, conveyor_cmd, lift_clear,
                  input ready);
  modport sink (input valid, mode, fork_target_mrev, conveyor_cmd, lift_clear,
                output ready);
endinterface

interface fcmc_cfg_if import fcmc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fcmc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module fcmc_cfg import fcmc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fcmc_cfg_if.sink  cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_CURRENT_LIMIT: cfg_d.current_limit_ma = cfg_i.data[CurWidth-1:0];
        CFG_JAM_TIME:      cfg_d.jam_time_ms      = cfg_i.data[JamWidth-1:0];
        CFG_FORK_UP:       cfg_d.fork_up_mrev     = cfg_i.data[ForkWidth-1:0];
        CFG_FORK_DOWN:     cfg_d.fork_down_mrev   = cfg_i.data[ForkWidth-1:0];
        CFG_FORK_DRIVE:    cfg_d.fork_drive_mrev  = cfg_i.data[ForkWidth-1:0];
        CFG_FORK_LOAD:     cfg_d.fork_load_mrev   = cfg_i.data[ForkWidth-1:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit_ma <= CurrentLimitRst;
      cfg_q.jam_time_ms      <= JamTimeRst;
      cfg_q.fork_up_mrev     <= ForkUpRst;
      cfg_q.fork_down_mrev   <= ForkDownRst;
      cfg_q.fork_drive_mrev  <= ForkDriveRst;
      cfg_q.fork_load_mrev   <= ForkLoadRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/fcmc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module fcmc_step import fcmc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  mode_e                mode_q, mode_d;
  logic [JamWidth-1:0]  jam_q, jam_d;
  logic [ForkWidth-1:0] target_q, target_d;
  logic                 lower_last_q, collect_last_q, primed_q;

  logic [JamWidth:0]    jam_sum;
  logic [JamWidth-1:0]  t;
  logic                 lower_press, collect_press, restart, over_limit, timed_out;
  conv_e                conv;

  assign jam_sum = {1'b0, jam_q} + {{(JamWidth + 1 - DtWidth){1'b0}}, item_i.elapsed_ms};

  always_comb begin
    // hold the timer on the priming tick
    if (!primed_q) begin
      t = jam_q;
    end else if (jam_sum[JamWidth]) begin
      t = JamMax;
    end else begin
      t = jam_sum[JamWidth-1:0];
    end
  end

  assign lower_press   = primed_q && item_i.lower_button && !lower_last_q;
  assign collect_press = primed_q && item_i.collect_button && !collect_last_q;
  assign over_limit    = item_i.conveyor_current_ma > cfg_i.current_limit_ma;
  assign timed_out     = t > cfg_i.jam_time_ms;

  always_comb begin
    mode_d  = mode_q;
    conv    = CONV_STOP;
    restart = 1'b0;
    case (mode_q)
      MODE_UP: begin
        if (lower_press) mode_d = MODE_DOWN;
      end
      MODE_DOWN: begin
        if (lower_press) mode_d = item_i.goal_near ? MODE_DRIVING : MODE_UP;
        if (collect_press) mode_d = MODE_LOADING;
      end
      MODE_DRIVING: begin
        if (lower_press) mode_d = MODE_DOWN;
        if (collect_press) mode_d = MODE_LOADING;
      end
      MODE_LOADING: begin
        if (collect_press) mode_d = MODE_DRIVING;
        if (lower_press) mode_d = MODE_DOWN;
        conv = CONV_FWD;
        if (over_limit) begin
          if (timed_out) begin
            mode_d  = MODE_UNJAM;
            restart = 1'b1;
          end
        end else begin
          restart = 1'b1;
        end
      end
      MODE_UNJAM: begin
        if (timed_out) mode_d = MODE_LOADING;
        conv = CONV_REV;
      end
      default: ;
    endcase
  end

  assign jam_d = restart ? '0 : t;

  always_comb begin
    case (mode_d)
      MODE_UP:      target_d = cfg_i.fork_up_mrev;
      MODE_DOWN:    target_d = cfg_i.fork_down_mrev;
      MODE_DRIVING: target_d = cfg_i.fork_drive_mrev;
      MODE_LOADING: target_d = cfg_i.fork_load_mrev;
      default:      target_d = target_q; // unjamming keeps the setpoint
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_UP;
      jam_q          <= '0;
      target_q       <= '0;
      lower_last_q   <= 1'b0;
      collect_last_q <= 1'b0;
      primed_q       <= 1'b0;
    end else if (en_i) begin
      mode_q         <= mode_d;
      jam_q          <= jam_d;
      target_q       <= target_d;
      lower_last_q   <= item_i.lower_button;
      collect_last_q <= item_i.collect_button;
      primed_q       <= 1'b1;
    end
  end

  assign res_o.mode             = mode_code(mode_d);
  assign res_o.fork_target_mrev = target_d;
  assign res_o.conveyor_cmd     = conv;
  assign res_o.lift_clear       = (mode_d == MODE_LOADING);

  a_unjam_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && mode_q == MODE_UNJAM |=> mode_q == MODE_UNJAM || mode_q == MODE_LOADING)
    else $error("unjamming left for a mode other than loading");

  a_unjam_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && mode_q == MODE_LOADING && mode_d == MODE_UNJAM |=> jam_q == '0)
    else $error("jam timer not restarted on entry to unjamming");

  a_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.conveyor_cmd == CONV_REV |-> mode_q == MODE_UNJAM)
    else $error("conveyor reversed outside unjamming");

  a_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> primed_q)
    else $error("edge detectors not primed after a tick");

endmodule

`default_nettype wire

FILE: rtl/fork_conveyor_mode_control.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat
// in_i      in   one control tick: buttons, goal flag, current, elapsed time
// out_o     out  one result per tick: mode, fork setpoint, conveyor, lift clear
// cfg_i     in   register write: index, data (always ready)
//
// Each tick is held in the input register and is worked out while it moves
// into the result register; one tick a cycle while the result is not stalled.
// The mode and jam timer state updates as the tick leaves the input register.
// A stalled result holds the result register; the input register still
// takes a beat whenever the tick ahead of it can move on.
// Reset clears the mode to up, the timer and the edge detectors, and loads
// the register defaults.
module fork_conveyor_mode_control import fcmc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fcmc_in_if.sink     in_i,
  fcmc_out_if.source  out_o,
  fcmc_cfg_if.sink    cfg_i
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_valid_q, out_valid_q, advance;

  fcmc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  fcmc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.lower_button        <= in_i.lower_button;
      item_q.collect_button      <= in_i.collect_button;
      item_q.goal_near           <= in_i.goal_near;
      item_q.conveyor_current_ma <= in_i.conveyor_current_ma;
      item_q.elapsed_ms          <= in_i.elapsed_ms;
    end
    if (advance) res_q <= res;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.mode             = res_q.mode;
  assign out_o.fork_target_mrev = res_q.fork_target_mrev;
  assign out_o.conveyor_cmd     = res_q.conveyor_cmd;
  assign out_o.lift_clear       = res_q.lift_clear;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(res_q))
    else $error("stalled result overwritten");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("waiting tick lost from input register");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("worked tick did not reach the result register");

endmodule

`default_nettype wire
